FILE: rtl/core/vpid_pkg.sv
// velocity pid controller: shared types, widths and codes
// no dependencies

package vpid_pkg;

  localparam int unsigned DataW   = 16;
  localparam int unsigned GainW   = 15;
  localparam int unsigned TsW     = 8;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 16;
  localparam int unsigned NumW    = 33;
  localparam int unsigned DenW    = 17;
  localparam int unsigned RemW    = DenW + 1;
  localparam int unsigned CntW    = 6;

  localparam logic [CntW-1:0] DivLast = CntW'(NumW - 1);
  localparam logic [CntW-1:0] MulLast = CntW'(2);

  localparam logic [CfgIdxW-1:0] CfgPropGain  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgIntTime   = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgDerivTime = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgSampTime  = 8'd3;

  localparam logic KindStep = 1'b0;
  localparam logic KindInit = 1'b1;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StMul  = 6'b000010,
    StLoad = 6'b000100,
    StDiv  = 6'b001000,
    StFin  = 6'b010000,
    StHold = 6'b100000
  } state_e;

endpackage

FILE: rtl/core/vpid_intf.sv
// velocity pid controller: channel interfaces for input, result and config
// depends on vpid_pkg

interface vpid_in_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic signed [vpid_pkg::DataW-1:0] measurement;
  logic signed [vpid_pkg::DataW-1:0] setpoint;
  logic        [vpid_pkg::GainW-1:0] upper_limit;
  modport source (output valid, kind, measurement, setpoint, upper_limit, input ready);
  modport sink   (input valid, kind, measurement, setpoint, upper_limit, output ready);
endinterface

interface vpid_out_if;
  logic                        valid;
  logic                        ready;
  logic [vpid_pkg::GainW-1:0]  drive;
  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

interface vpid_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [vpid_pkg::CfgIdxW-1:0]  index;
  logic [vpid_pkg::CfgDatW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/velocity_pid_controller.sv
// velocity pid controller top level: sequencer around one multiplier and one divider
// depends on vpid_pkg and the interfaces in vpid_intf
//
// channel  dir  transfer when           payload
// in_i     in   valid & ready           kind, measurement, setpoint, upper_limit
// out_o    out  valid & ready           drive
// cfg_i    in   valid (ready tied high) index, data
//
// a sample runs from transfer to result as three passes through the
// shared 16x16 multiplier, then the add and clamp. an init runs, per
// gain, one multiply, one load and 33 steps of the restoring divider, then
// the finish state. the sequencer returns to idle before the next transfer.
// reset clears history, drive, gains and config, not payload; no clearing pass.
// a result waiting on out_o holds the sequencer before it goes idle.

module velocity_pid_controller (
  input  logic            clk_i,
  input  logic            rst_ni,
  vpid_in_if.sink         in_i,
  vpid_out_if.source      out_o,
  vpid_cfg_if.sink        cfg_i
);

  vpid_pkg::state_e state_q, state_d;

  logic [vpid_pkg::GainW-1:0] kc_q;
  logic [vpid_pkg::DataW-1:0] ti_q, td_q;
  logic [vpid_pkg::TsW-1:0]   ts_q;

  logic [vpid_pkg::DataW-1:0] y1_q, y2_q, drive_q, ki_q, kd_q;

  logic                       kind_q;
  logic [vpid_pkg::DataW-1:0] y_q, w_q;
  logic [vpid_pkg::GainW-1:0] lim_q;

  logic                       phase_q;
  logic [vpid_pkg::CntW-1:0]  cnt_q;
  logic [vpid_pkg::DataW-1:0] acc_q;
  logic [31:0]                prod_q;
  logic [vpid_pkg::NumW-1:0]  num_q;
  logic [vpid_pkg::RemW-1:0]  rem_q;
  logic [vpid_pkg::DenW-1:0]  den_q;
  logic                       den_zero_q;

  logic                       out_valid_q;
  logic [vpid_pkg::GainW-1:0] out_drive_q;

  logic [vpid_pkg::DataW-1:0] mul_a, mul_b;
  logic [31:0]                mul_p;
  logic [vpid_pkg::RemW-1:0]  trial, rem_sub;
  logic                       q_bit;
  logic [vpid_pkg::NumW-1:0]  num_next;
  logic [vpid_pkg::DataW-1:0] u_sum;
  logic [vpid_pkg::DataW-1:0] u_clamp;
  logic                       in_xfer, slot_free, out_load;

  assign in_i.ready  = (state_q == vpid_pkg::StIdle);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.drive = out_drive_q;
  assign slot_free   = !out_valid_q || out_o.ready;
  assign out_load    = slot_free &&
                       ((state_q == vpid_pkg::StFin) || (state_q == vpid_pkg::StHold));

  // shared multiplier operands
  always_comb begin
    mul_a = {1'b0, kc_q};
    mul_b = {{(vpid_pkg::DataW-vpid_pkg::TsW){1'b0}}, ts_q};
    if (kind_q == vpid_pkg::KindInit) begin
      if (phase_q) begin
        mul_b = td_q;
      end
    end else begin
      unique case (cnt_q)
        vpid_pkg::CntW'(0): begin
          mul_b = y1_q - y_q;
        end
        vpid_pkg::CntW'(1): begin
          mul_a = ki_q;
          mul_b = w_q - y_q;
        end
        default: begin
          mul_a = kd_q;
          mul_b = (y1_q << 1) - y_q - y2_q;
        end
      endcase
    end
  end

  assign mul_p = 32'(mul_a) * 32'(mul_b);

  // restoring divider step
  assign trial    = {rem_q[vpid_pkg::DenW-1:0], num_q[vpid_pkg::NumW-1]};
  assign q_bit    = (trial >= {1'b0, den_q});
  assign rem_sub  = trial - {1'b0, den_q};
  assign num_next = {num_q[vpid_pkg::NumW-2:0], q_bit};

  // drive update and clamp
  assign u_sum = drive_q + acc_q;
  always_comb begin
    if (u_sum[vpid_pkg::DataW-1]) begin
      u_clamp = '0;
    end else if (u_sum > {1'b0, lim_q}) begin
      u_clamp = {1'b0, lim_q};
    end else begin
      u_clamp = u_sum;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vpid_pkg::StIdle: if (in_xfer) state_d = vpid_pkg::StMul;
      vpid_pkg::StMul: begin
        if (kind_q == vpid_pkg::KindInit) begin
          state_d = vpid_pkg::StLoad;
        end else if (cnt_q == vpid_pkg::MulLast) begin
          state_d = vpid_pkg::StFin;
        end
      end
      vpid_pkg::StLoad: state_d = vpid_pkg::StDiv;
      vpid_pkg::StDiv: begin
        if (cnt_q == vpid_pkg::DivLast) begin
          state_d = phase_q ? vpid_pkg::StFin : vpid_pkg::StMul;
        end
      end
      vpid_pkg::StFin:  state_d = slot_free ? vpid_pkg::StIdle : vpid_pkg::StHold;
      vpid_pkg::StHold: if (slot_free) state_d = vpid_pkg::StIdle;
      default:          state_d = vpid_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vpid_pkg::StIdle;
      kc_q        <= '0;
      ti_q        <= '0;
      td_q        <= '0;
      ts_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
      drive_q     <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      kind_q      <= vpid_pkg::KindStep;
      phase_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          vpid_pkg::CfgPropGain:  kc_q <= cfg_i.data[vpid_pkg::GainW-1:0];
          vpid_pkg::CfgIntTime:   ti_q <= cfg_i.data;
          vpid_pkg::CfgDerivTime: td_q <= cfg_i.data;
          vpid_pkg::CfgSampTime:  ts_q <= cfg_i.data[vpid_pkg::TsW-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        vpid_pkg::StIdle: begin
          if (in_xfer) begin
            kind_q  <= in_i.kind;
            phase_q <= 1'b0;
            cnt_q   <= '0;
          end
        end
        vpid_pkg::StMul: begin
          if (kind_q == vpid_pkg::KindStep) begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        vpid_pkg::StLoad: begin
          cnt_q <= '0;
        end
        vpid_pkg::StDiv: begin
          if (cnt_q == vpid_pkg::DivLast) begin
            cnt_q   <= '0;
            phase_q <= 1'b1;
            if (phase_q) begin
              kd_q <= den_zero_q ? '0 : num_next[vpid_pkg::DataW-1:0];
            end else begin
              ki_q <= den_zero_q ? '0 : num_next[vpid_pkg::DataW-1:0];
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        vpid_pkg::StFin: begin
          if (kind_q == vpid_pkg::KindInit) begin
            y1_q <= y_q;
            y2_q <= y_q;
          end else begin
            drive_q <= u_clamp;
            y2_q    <= y1_q;
            y1_q    <= y_q;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      vpid_pkg::StIdle: begin
        if (in_xfer) begin
          y_q   <= in_i.measurement;
          w_q   <= in_i.setpoint;
          lim_q <= in_i.upper_limit;
          acc_q <= '0;
        end
      end
      vpid_pkg::StMul: begin
        prod_q <= mul_p;
        acc_q  <= acc_q + mul_p[vpid_pkg::DataW-1:0];
      end
      vpid_pkg::StLoad: begin
        rem_q <= '0;
        if (phase_q) begin
          num_q      <= {prod_q, 1'b0} + vpid_pkg::NumW'(ts_q);
          den_q      <= {{(vpid_pkg::DenW-vpid_pkg::TsW-1){1'b0}}, ts_q, 1'b0};
          den_zero_q <= (ts_q == '0);
        end else begin
          num_q      <= {prod_q, 1'b0} + vpid_pkg::NumW'(ti_q);
          den_q      <= {ti_q, 1'b0};
          den_zero_q <= (ti_q == '0);
        end
      end
      vpid_pkg::StDiv: begin
        num_q <= num_next;
        rem_q <= q_bit ? rem_sub : trial;
      end
      vpid_pkg::StFin: begin
        if (slot_free) begin
          out_drive_q <= (kind_q == vpid_pkg::KindInit) ? drive_q[vpid_pkg::GainW-1:0]
                                                         : u_clamp[vpid_pkg::GainW-1:0];
        end
      end
      vpid_pkg::StHold: begin
        if (slot_free) begin
          out_drive_q <= drive_q[vpid_pkg::GainW-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule
